// ===== rtl/b2si_pkg.sv =====
// Shared types and constants for the binary64 to scaled integer converter.
// Depends on nothing; every module file of the block imports it.
package b2si_pkg;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NONFINITE = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   localparam logic [1:0] CSR_SCALE        = 2'd0;
   localparam logic [1:0] CSR_MAG_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_LIMIT_ENABLE = 2'd2;

   localparam logic [63:0] SCALE_RESET     = 64'd1000000;
   localparam logic [62:0] MAG_LIMIT_RESET = {63{1'b1}};

   localparam logic [10:0] EXP_ALL_ONES   = 11'h7ff;
   localparam logic [10:0] EXP_BIAS_SHIFT = 11'd1075;

   localparam logic [63:0] INT64_MAG_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] INT64_MAG_POS = 64'h7fff_ffff_ffff_ffff;

   localparam int PROD_W = 117;

   typedef struct packed {
      logic       neg;
      logic       err;
      logic [1:0] err_status;
      logic       left;
      logic       big;
      logic [6:0] shamt;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [52:0] sig;
   } dec_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [63:0] p00;
      logic [63:0] p01;
      logic [52:0] p10;
      logic [52:0] p11;
   } pp_type;

   typedef struct packed {
      ctl_type           ctl;
      logic [PROD_W-1:0] product;
   } prod_type;

   typedef struct packed {
      logic        neg;
      logic        err;
      logic [1:0]  err_status;
      logic        hi_nz;
      logic [63:0] mag;
      logic        guard;
      logic        sticky;
   } shf_type;

   typedef struct packed {
      logic        neg;
      logic        err;
      logic [1:0]  err_status;
      logic        hi_nz;
      logic [63:0] mag;
   } rnd_type;

endpackage

// ===== rtl/b2si_req_if.sv =====
// Input channel of the converter: valid, ready and the raw binary64 bits.
// No dependencies.
interface b2si_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_bits;

   modport source (output valid, output value_bits, input ready);
   modport sink (input valid, input value_bits, output ready);
endinterface

// ===== rtl/b2si_rsp_if.sv =====
// Result channel of the converter: valid, ready, result and status.
// No dependencies.
interface b2si_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] result;
   logic [1:0]         status;

   modport source (output valid, output result, output status, input ready);
   modport sink (input valid, input result, input status, output ready);
endinterface

// ===== rtl/b2si_decode.sv =====
// First pipeline stage: splits the binary64 word into sign, significand and
// shift control, and flags the early errors. Uses b2si_pkg.
module b2si_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [63:0]       value_bits,
   input  logic              scale_zero,
   output logic              out_valid,
   input  logic              out_ready,
   output b2si_pkg::dec_type out_data
);
   import b2si_pkg::*;

   logic        valid_ff;
   dec_type     data_ff;
   dec_type     data_in;
   logic [10:0] raw_exp;
   logic [10:0] eff_exp;
   logic [10:0] lsh;
   logic [10:0] rsh;
   logic        nonfinite;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      raw_exp   = value_bits[62:52];
      nonfinite = (raw_exp == EXP_ALL_ONES);
      eff_exp   = (raw_exp == 11'd0) ? 11'd1 : raw_exp;
      lsh       = eff_exp - EXP_BIAS_SHIFT;
      rsh       = EXP_BIAS_SHIFT - eff_exp;

      data_in.ctl.neg        = value_bits[63];
      data_in.ctl.err        = nonfinite || scale_zero;
      data_in.ctl.err_status = nonfinite ? ST_NONFINITE : ST_OVERFLOW;
      data_in.sig            = {(raw_exp != 11'd0), value_bits[51:0]};
      data_in.ctl.left       = (eff_exp >= EXP_BIAS_SHIFT);
      if (data_in.ctl.left) begin
         data_in.ctl.big   = |lsh[10:6];
         data_in.ctl.shamt = {1'b0, lsh[5:0]};
      end else begin
         data_in.ctl.big   = |rsh[10:7];
         data_in.ctl.shamt = rsh[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/b2si_mult.sv =====
// Two pipeline stages: 32-bit partial products of significand and scale,
// then their sum into the 117-bit product. Uses b2si_pkg.
module b2si_mult (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  b2si_pkg::dec_type  in_data,
   input  logic [63:0]        scale,
   output logic               out_valid,
   input  logic               out_ready,
   output b2si_pkg::prod_type out_data
);
   import b2si_pkg::*;

   logic     pp_valid_ff;
   pp_type   pp_ff;
   pp_type   pp_in;
   logic     pp_ready;
   logic     sum_valid_ff;
   prod_type sum_ff;
   prod_type sum_in;

   assign pp_ready  = !sum_valid_ff || out_ready;
   assign in_ready  = !pp_valid_ff || pp_ready;
   assign out_valid = sum_valid_ff;
   assign out_data  = sum_ff;

   always_comb begin
      pp_in.ctl = in_data.ctl;
      pp_in.p00 = 64'(in_data.sig[31:0]) * 64'(scale[31:0]);
      pp_in.p01 = 64'(in_data.sig[31:0]) * 64'(scale[63:32]);
      pp_in.p10 = 53'(in_data.sig[52:32]) * 53'(scale[31:0]);
      pp_in.p11 = 53'(in_data.sig[52:32]) * 53'(scale[63:32]);
   end

   always_comb begin
      sum_in.ctl     = pp_ff.ctl;
      sum_in.product = PROD_W'(pp_ff.p00)
                     + (PROD_W'(pp_ff.p01) << 32)
                     + (PROD_W'(pp_ff.p10) << 32)
                     + (PROD_W'(pp_ff.p11) << 64);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            pp_valid_ff <= in_valid;
         end
         if (pp_ready) begin
            sum_valid_ff <= pp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pp_ff <= pp_in;
      end
      if (pp_ready && pp_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== rtl/b2si_align.sv =====
// Two pipeline stages: left shift with overflow check or right shift with
// guard and sticky, then round half to even. Uses b2si_pkg.
module b2si_align (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  b2si_pkg::prod_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output b2si_pkg::rnd_type  out_data
);
   import b2si_pkg::*;

   logic              shf_valid_ff;
   shf_type           shf_ff;
   shf_type           shf_in;
   logic              shf_ready;
   logic              rnd_valid_ff;
   rnd_type           rnd_ff;
   rnd_type           rnd_in;
   logic [PROD_W-1:0] shr;
   logic [PROD_W-1:0] guard_vec;
   logic [PROD_W-1:0] low_mask;
   logic [PROD_W-1:0] lhi;
   logic [6:0]        s_minus1;
   logic              inc;
   logic [64:0]       sum65;

   assign shf_ready = !rnd_valid_ff || out_ready;
   assign in_ready  = !shf_valid_ff || shf_ready;
   assign out_valid = rnd_valid_ff;
   assign out_data  = rnd_ff;

   always_comb begin
      s_minus1  = in_data.ctl.shamt - 7'd1;
      shr       = in_data.product >> in_data.ctl.shamt;
      guard_vec = in_data.product >> s_minus1;
      low_mask  = ~({PROD_W{1'b1}} << s_minus1);
      lhi       = in_data.product >> (7'd64 - in_data.ctl.shamt);

      shf_in.neg        = in_data.ctl.neg;
      shf_in.err        = in_data.ctl.err;
      shf_in.err_status = in_data.ctl.err_status;
      if (in_data.ctl.left) begin
         shf_in.hi_nz  = in_data.ctl.big || (|lhi);
         shf_in.mag    = in_data.product[63:0] << in_data.ctl.shamt[5:0];
         shf_in.guard  = 1'b0;
         shf_in.sticky = 1'b0;
      end else if (in_data.ctl.big) begin
         shf_in.hi_nz  = 1'b0;
         shf_in.mag    = 64'd0;
         shf_in.guard  = 1'b0;
         shf_in.sticky = 1'b0;
      end else begin
         shf_in.hi_nz  = |shr[PROD_W-1:64];
         shf_in.mag    = shr[63:0];
         shf_in.guard  = guard_vec[0];
         shf_in.sticky = |(in_data.product & low_mask);
      end
   end

   always_comb begin
      inc               = shf_ff.guard && (shf_ff.sticky || shf_ff.mag[0]);
      sum65             = {1'b0, shf_ff.mag} + {64'd0, inc};
      rnd_in.neg        = shf_ff.neg;
      rnd_in.err        = shf_ff.err;
      rnd_in.err_status = shf_ff.err_status;
      rnd_in.hi_nz      = shf_ff.hi_nz || sum65[64];
      rnd_in.mag        = sum65[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shf_valid_ff <= 1'b0;
         rnd_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            shf_valid_ff <= in_valid;
         end
         if (shf_ready) begin
            rnd_valid_ff <= shf_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         shf_ff <= shf_in;
      end
      if (shf_ready && shf_valid_ff) begin
         rnd_ff <= rnd_in;
      end
   end

endmodule

// ===== rtl/b2si_finish.sv =====
// Output stage: int64 range and magnitude limit checks, sign application
// and status selection into the result register. Uses b2si_pkg.
module b2si_finish (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  b2si_pkg::rnd_type in_data,
   input  logic [62:0]       magnitude_limit,
   input  logic              limit_enable,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [63:0]       out_result,
   output logic [1:0]        out_status
);
   import b2si_pkg::*;

   logic        valid_ff;
   logic [63:0] result_ff;
   logic [63:0] result_in;
   logic [1:0]  status_ff;
   logic [1:0]  status_in;
   logic [63:0] bound;
   logic        ovf;
   logic        outside;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign out_status = status_ff;

   always_comb begin
      bound   = in_data.neg ? INT64_MAG_NEG : INT64_MAG_POS;
      ovf     = in_data.hi_nz || (in_data.mag > bound);
      outside = limit_enable && (in_data.mag > {1'b0, magnitude_limit});
      if (in_data.err) begin
         status_in = in_data.err_status;
         result_in = 64'd0;
      end else if (ovf) begin
         status_in = ST_OVERFLOW;
         result_in = 64'd0;
      end else if (outside) begin
         status_in = ST_RANGE;
         result_in = 64'd0;
      end else begin
         status_in = ST_OK;
         result_in = in_data.neg ? (64'd0 - in_data.mag) : in_data.mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff <= result_in;
         status_ff <= status_in;
      end
   end

endmodule

// ===== rtl/binary64_to_scaled_integer.sv =====
// Top level of the binary64 to scaled int64 converter: configuration
// registers and the six-stage pipeline. Uses b2si_pkg, both channel
// interfaces and the b2si_decode, b2si_mult, b2si_align, b2si_finish stages.
//
//   channel   direction  payload
//   req_chan  in         value_bits[63:0]
//   rsp_chan  out        result[63:0] signed, status[1:0]
//   csr_*     in         csr_we, csr_index[1:0], csr_wdata[63:0]
//
// One transaction per cycle while rsp_chan is not stalled.
// Stages: decode, partial products, product sum, shift, round, check/sign.
// Every stage has its own valid bit and takes new data when empty or when
// the next stage moves, so a stalled output fills bubbles before req ready
// drops. Reset clears all valid bits and loads the register defaults.
module binary64_to_scaled_integer (
   input  logic        clock,
   input  logic        reset,
   b2si_req_if.sink    req_chan,
   b2si_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import b2si_pkg::*;

   logic [63:0] scale_ff;
   logic [62:0] limit_ff;
   logic        limit_en_ff;

   logic     dec_valid;
   logic     dec_ready;
   dec_type  dec_data;
   logic     mul_valid;
   logic     mul_ready;
   prod_type mul_data;
   logic     aln_valid;
   logic     aln_ready;
   rnd_type  aln_data;
   logic [63:0] fin_result;
   logic [63:0] rsp_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= SCALE_RESET;
         limit_ff    <= MAG_LIMIT_RESET;
         limit_en_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCALE: begin
               scale_ff <= csr_wdata;
            end
            CSR_MAG_LIMIT: begin
               limit_ff <= csr_wdata[62:0];
            end
            CSR_LIMIT_ENABLE: begin
               limit_en_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   b2si_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .value_bits (req_chan.value_bits),
      .scale_zero (scale_ff == 64'd0),
      .out_valid  (dec_valid),
      .out_ready  (dec_ready),
      .out_data   (dec_data)
   );

   b2si_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .scale     (scale_ff),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_data  (mul_data)
   );

   b2si_align u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_data   (mul_data),
      .out_valid (aln_valid),
      .out_ready (aln_ready),
      .out_data  (aln_data)
   );

   b2si_finish u_finish (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (aln_valid),
      .in_ready        (aln_ready),
      .in_data         (aln_data),
      .magnitude_limit (limit_ff),
      .limit_enable    (limit_en_ff),
      .out_valid       (rsp_chan.valid),
      .out_ready       (rsp_chan.ready),
      .out_result      (fin_result),
      .out_status      (rsp_chan.status)
   );

   assign rsp_chan.result = fin_result;
   assign rsp_mag = fin_result[63] ? (64'd0 - fin_result) : fin_result;

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status != ST_OK) |-> fin_result == 64'd0)
      else $error("nonzero result with error status");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   a_limit_held : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == ST_OK) && limit_en_ff
      |-> rsp_mag <= {1'b0, limit_ff})
      else $error("ok result beyond magnitude limit");

   a_full_on_stall : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("input stalled while output is free");

endmodule

// ===== test/b2si_result_checker.sv =====
// Result checker for the binary64 to scaled integer converter: watches both
// channels and the register port, predicts each conversion and compares.
// Depends on b2si_pkg and the b2si_req_if / b2si_rsp_if interfaces.
module b2si_result_checker (
   input  logic       clock,
   input  logic       reset,
   b2si_req_if        req_chan,
   b2si_rsp_if        rsp_chan,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [63:0] csr_wdata,
   output int         pending_count,
   output int         error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import b2si_pkg::*;

   localparam int SUBNORMAL_EXP = -1074;

   typedef struct packed {
      logic [63:0] result;
      logic [1:0]  status;
   } conversion_type;

   logic [63:0] scale_reg;
   logic [62:0] mag_limit_reg;
   logic        limit_enable_reg;
   conversion_type expected_conversions[$];

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch, got %h, want %h", $time, field, got, want);
      error_count++;
   endtask

   function automatic conversion_type convert_binary64(input logic [63:0] bits);
      conversion_type out;
      logic        neg;
      logic [10:0] raw_exp;
      logic [52:0] sig;
      logic [127:0] product;
      logic [127:0] mag;
      logic [127:0] low_mask;
      logic [191:0] widened;
      int          exponent;
      int          s;
      out.result = '0;
      out.status = ST_OK;
      neg = bits[63];
      raw_exp = bits[62:52];
      if (raw_exp == EXP_ALL_ONES) begin
         out.status = ST_NONFINITE;
         return out;
      end
      if (scale_reg == '0) begin
         out.status = ST_OVERFLOW;
         return out;
      end
      if (bits[62:0] == '0)
         return out;
      sig = (raw_exp == '0) ? {1'b0, bits[51:0]} : {1'b1, bits[51:0]};
      exponent = (raw_exp == '0) ? SUBNORMAL_EXP : int'(raw_exp) - int'(EXP_BIAS_SHIFT);
      product = {75'd0, sig} * {64'd0, scale_reg};
      if (exponent >= 0) begin
         if (exponent >= 64) begin
            out.status = ST_OVERFLOW;
            return out;
         end
         widened = {64'd0, product} << exponent;
         if (widened[191:64] != '0) begin
            out.status = ST_OVERFLOW;
            return out;
         end
         mag = widened[127:0];
      end else begin
         s = -exponent;
         if (s >= 128) begin
            mag = '0;
         end else begin
            mag = product >> s;
            low_mask = (128'd1 << (s - 1)) - 128'd1;
            if (product[s - 1] && (((product & low_mask) != '0) || mag[0]))
               mag = mag + 128'd1;
         end
      end
      if (mag[127:64] != '0 || mag[63:0] > (neg ? INT64_MAG_NEG : INT64_MAG_POS)) begin
         out.status = ST_OVERFLOW;
         return out;
      end
      if (limit_enable_reg && mag[63:0] > {1'b0, mag_limit_reg}) begin
         out.status = ST_RANGE;
         return out;
      end
      out.result = neg ? (64'd0 - mag[63:0]) : mag[63:0];
      return out;
   endfunction

   always @(posedge clock) begin
      conversion_type want;
      if (reset) begin
         scale_reg = SCALE_RESET;
         mag_limit_reg = MAG_LIMIT_RESET;
         limit_enable_reg = 1'b0;
         expected_conversions.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCALE: scale_reg = csr_wdata;
               CSR_MAG_LIMIT: mag_limit_reg = csr_wdata[62:0];
               CSR_LIMIT_ENABLE: limit_enable_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            expected_conversions.insert(expected_conversions.size(),
                                        convert_binary64(req_chan.value_bits));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_conversions.size() == 0) begin
               report_mismatch("unrequested result", rsp_chan.result, '0);
            end else begin
               want = expected_conversions.pop_front();
               if (rsp_chan.result !== want.result)
                  report_mismatch("result", rsp_chan.result, want.result);
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", {62'd0, rsp_chan.status}, {62'd0, want.status});
            end
         end
      end
      pending_count <= expected_conversions.size();
   end

endmodule

// ===== test/tb_binary64_to_scaled_integer.sv =====
// Testbench top for the binary64 to scaled integer converter: clock, reset,
// register writes, randomly paced traffic on both channels and the verdict.
// Depends on b2si_pkg, both channel interfaces, binary64_to_scaled_integer and b2si_result_checker.
module tb_binary64_to_scaled_integer;
   timeunit 1ns;
   timeprecision 1ps;

   import b2si_pkg::*;

   localparam logic [1:0]  CSR_UNUSED   = 2'd3;
   localparam logic [63:0] SCALE_MICRO  = 64'd1000000;
   localparam logic [63:0] SCALE_NANO   = 64'd1000000000;
   localparam int          MAX_WAIT     = 14;
   localparam int          LONG_HOLD    = 200;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_PHASES = 9;
   localparam int          PHASE_ITEMS  = 50;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;
   logic [63:0] cur_scale;
   bit          sender_burst;
   bit          receiver_burst;
   bit          hold_pending;
   int          cycle_count = 0;
   int          pending_count;
   int          error_count;

   b2si_req_if req_chan();
   b2si_rsp_if rsp_chan();

   binary64_to_scaled_integer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   b2si_result_checker conversion_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_binary64_to_scaled_integer NOT OK");
         $finish;
      end
   end

   task automatic write_csr(input logic [1:0] index, input logic [63:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [63:0] scale, input logic [62:0] limit,
                            input logic enable);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_csr(CSR_SCALE, scale);
      write_csr(CSR_MAG_LIMIT, {junk[63], limit});
      write_csr(CSR_LIMIT_ENABLE, {junk[63:1], enable});
      cur_scale = scale;
   endtask

   task automatic send_value(input logic [63:0] bits);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value_bits <= bits;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold the sender until every outstanding conversion has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] random_value(input logic [63:0] scale);
      logic [63:0] bits;
      int          scale_msb;
      int          kind;
      int          t;
      int          e;
      scale_msb = 0;
      for (int i = 0; i < 64; i++)
         if (scale[i])
            scale_msb = i;
      bits = {$urandom, $urandom};
      kind = $urandom_range(0, 99);
      t = $urandom_range(0, 66);
      if (kind < 65) begin
         e = 1023 + t - 2 - scale_msb;
         if (kind >= 50)
            e = 1023 + 62 - scale_msb + t % 3;
         if (e < 1)
            e = 1;
         if (e > 2046)
            e = 2046;
         bits[62:52] = e[10:0];
         if (kind < 15)
            bits[47:0] = '0;
      end else if (kind < 73) begin
         bits[62:52] = '0;
      end else if (kind < 79) begin
         bits[62:52] = EXP_ALL_ONES;
      end else if (kind < 84) begin
         bits[62:0] = '0;
      end
      return bits;
   endfunction

   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_pending) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_pending = 1'b0;
         end
         stall = receiver_burst ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      int          phase;
      logic [63:0] scale_pick;
      logic [62:0] limit_pick;
      logic        enable_pick;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_SCALE;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.value_bits <= '0;
      sender_burst = 1'b0;
      receiver_burst = 1'b0;
      hold_pending = 1'b0;
      cur_scale = SCALE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // register defaults
      send_value(64'h0000_0000_0000_0000);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'h7ff0_0000_0000_0000);
      send_value(64'hfff8_0000_0000_0001);
      send_value(64'h3ff0_0000_0000_0000);
      send_value(64'hbff0_0000_0000_0000);
      send_value(64'h0000_0000_0000_0001);
      send_value(64'h7fef_ffff_ffff_ffff);
      send_value(64'h3eb0_c6f7_a0b5_ed8d);
      drain();

      // unit scale: ties and the int64 boundaries
      configure(64'd1, MAG_LIMIT_RESET, 1'b1);
      write_csr(CSR_UNUSED, 64'd0);
      send_value(64'h3fe0_0000_0000_0000);
      send_value(64'h3ff8_0000_0000_0000);
      send_value(64'h4004_0000_0000_0000);
      send_value(64'hc004_0000_0000_0000);
      send_value(64'h43e0_0000_0000_0000);
      send_value(64'hc3e0_0000_0000_0000);
      send_value(64'h43df_ffff_ffff_ffff);
      send_value(64'h000f_ffff_ffff_ffff);
      drain();

      configure(64'd0, MAG_LIMIT_RESET, 1'b0);
      send_value(64'h0000_0000_0000_0000);
      send_value(64'h7ff0_0000_0000_0001);
      send_value(64'h3ff0_0000_0000_0000);
      drain();

      configure('1, 63'd0, 1'b1);
      send_value(64'h3ff0_0000_0000_0000);
      send_value(64'h3c00_0000_0000_0000);
      send_value(64'h0000_0000_0000_0000);
      send_value(64'h0010_0000_0000_0000);
      drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0: scale_pick = 64'd1;
            1: scale_pick = SCALE_MICRO;
            2: scale_pick = SCALE_NANO;
            3: scale_pick = 64'd1 << $urandom_range(0, 63);
            4: scale_pick = {$urandom, $urandom};
            5: scale_pick = 64'($urandom_range(1, 1000));
            6: scale_pick = '1;
            default: scale_pick = 64'd3;
         endcase
         case ($urandom_range(0, 3))
            0: limit_pick = '1;
            1: limit_pick = 63'd0;
            2: limit_pick = 63'({$urandom, $urandom});
            default: limit_pick = 63'({$urandom, $urandom} >> $urandom_range(0, 62));
         endcase
         enable_pick = 1'($urandom_range(0, 1));
         configure(scale_pick, limit_pick, enable_pick);
         sender_burst = ($urandom_range(0, 3) == 0);
         receiver_burst = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            hold_pending = 1'b1;
            sender_burst = 1'b1;
         end
         repeat (PHASE_ITEMS) send_value(random_value(cur_scale));
         drain();
      end

      if (error_count == 0)
         $display("tb_binary64_to_scaled_integer OK");
      else
         $display("tb_binary64_to_scaled_integer NOT OK");
      $finish;
   end

endmodule
